### hw/rtl/eintc_pkg.sv
`timescale 1ns / 1ps

package eintc_pkg;

  // Line configuration
  localparam int LINE_COUNT        = 16;
  localparam int FIRST_GROUP_LINE  = 5;
  localparam int MAX_LINES         = 16;
  localparam int SINGLE_BITS       = 5;
  localparam int SECOND_GROUP_LINE = 10;

  // Field widths
  localparam int REQ_W  = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 16;
  localparam int PORT_W = 4;
  localparam int SEL_W  = 4;
  localparam int IRQ_W  = 7;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd2;

  // Register map
  localparam logic [ADDR_W-1:0] ADDR_MASK    = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_RISING  = 3'd1;
  localparam logic [ADDR_W-1:0] ADDR_FALLING = 3'd2;
  localparam logic [ADDR_W-1:0] ADDR_PENDING = 3'd3;
  localparam logic [ADDR_W-1:0] ADDR_SEL0    = 3'd4;
  localparam logic [ADDR_W-1:0] ADDR_SEL1    = 3'd5;
  localparam logic [ADDR_W-1:0] ADDR_SEL2    = 3'd6;
  localparam logic [ADDR_W-1:0] ADDR_SEL3    = 3'd7;

  // Item-wide controls broadcast to every lane
  typedef struct packed {
    logic              mask_we;
    logic              rise_we;
    logic              fall_we;
    logic              pend_we;
    logic              sample;
    logic [PORT_W-1:0] port;
  } lane_ctl_t;

  // Per-lane state seen by the merge stage
  typedef struct packed {
    logic             mask;
    logic             rise;
    logic             fall;
    logic             pend;
    logic [SEL_W-1:0] sel;
    logic             active;
  } lane_stat_t;

  // Which irq output bit a line drives
  function automatic logic [2:0] line_irq_bit(input int l);
    logic [2:0] b;
    if (l < FIRST_GROUP_LINE && l < SINGLE_BITS) begin
      b = 3'(l);
    end else if (l < SECOND_GROUP_LINE) begin
      b = 3'd5;
    end else begin
      b = 3'd6;
    end
    return b;
  endfunction

endpackage

### hw/rtl/eintc_lane.sv
`timescale 1ns / 1ps

module eintc_lane (
  input  logic                     clk,
  input  logic                     rst,
  input  eintc_pkg::lane_ctl_t     ctl,
  input  logic                     sel_we,
  input  logic                     data_bit,
  input  logic [eintc_pkg::SEL_W-1:0] sel_data,
  input  logic                     level,
  output eintc_pkg::lane_stat_t    stat
);
  import eintc_pkg::*;

  logic             mask, mask_next;
  logic             rise_en, rise_en_next;
  logic             fall_en, fall_en_next;
  logic             pend, pend_next;
  logic             last_level, last_level_next;
  logic [SEL_W-1:0] sel, sel_next;
  logic             hit;
  logic             edge_set;

  // Edge detect on the sampled pin when this line watches that port
  assign hit      = ctl.sample && (sel == ctl.port);
  assign edge_set = hit && ((level && !last_level && rise_en) ||
                            (!level && last_level && fall_en));

  always_comb begin
    mask_next       = ctl.mask_we ? data_bit : mask;
    rise_en_next    = ctl.rise_we ? data_bit : rise_en;
    fall_en_next    = ctl.fall_we ? data_bit : fall_en;
    sel_next        = sel_we ? sel_data : sel;
    last_level_next = hit ? level : last_level;
    // write 1 clears; an edge sets regardless of mask
    pend_next       = (pend && !(ctl.pend_we && data_bit)) || edge_set;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask       <= 1'b0;
      rise_en    <= 1'b0;
      fall_en    <= 1'b0;
      pend       <= 1'b0;
      last_level <= 1'b0;
      sel        <= '0;
    end else begin
      mask       <= mask_next;
      rise_en    <= rise_en_next;
      fall_en    <= fall_en_next;
      pend       <= pend_next;
      last_level <= last_level_next;
      sel        <= sel_next;
    end
  end

  // Current values for reads, post-update request for irq
  always_comb begin
    stat.mask   = mask;
    stat.rise   = rise_en;
    stat.fall   = fall_en;
    stat.pend   = pend;
    stat.sel    = sel;
    stat.active = pend_next && mask_next;
  end

endmodule

### hw/rtl/eintc_merge.sv
`timescale 1ns / 1ps

module eintc_merge (
  input  eintc_pkg::lane_stat_t [eintc_pkg::LINE_COUNT-1:0] stat,
  input  logic                         rd_en,
  input  logic [eintc_pkg::ADDR_W-1:0] reg_addr,
  output logic [eintc_pkg::DATA_W-1:0] read_data,
  output logic [eintc_pkg::IRQ_W-1:0]  irq_lines
);
  import eintc_pkg::*;

  logic [MAX_LINES-1:0]       mask_v, rise_v, fall_v, pend_v, active_v;
  logic [MAX_LINES*SEL_W-1:0] sel_flat;
  logic [DATA_W-1:0]          reg_v;

  // Gather lane state, absent lines read as zero
  for (genvar l = 0; l < MAX_LINES; l++) begin : g_gather
    if (l < LINE_COUNT) begin : g_on
      assign mask_v[l]               = stat[l].mask;
      assign rise_v[l]               = stat[l].rise;
      assign fall_v[l]               = stat[l].fall;
      assign pend_v[l]               = stat[l].pend;
      assign active_v[l]             = stat[l].active;
      assign sel_flat[l*SEL_W +: SEL_W] = stat[l].sel;
    end else begin : g_off
      assign mask_v[l]               = 1'b0;
      assign rise_v[l]               = 1'b0;
      assign fall_v[l]               = 1'b0;
      assign pend_v[l]               = 1'b0;
      assign active_v[l]             = 1'b0;
      assign sel_flat[l*SEL_W +: SEL_W] = '0;
    end
  end

  // Register read decode
  always_comb begin
    unique case (reg_addr) inside
      ADDR_MASK:    reg_v = mask_v;
      ADDR_RISING:  reg_v = rise_v;
      ADDR_FALLING: reg_v = fall_v;
      ADDR_PENDING: reg_v = pend_v;
      ADDR_SEL0, ADDR_SEL1, ADDR_SEL2, ADDR_SEL3:
        reg_v = sel_flat[{reg_addr[1:0], 4'b0000} +: DATA_W];
      default:      reg_v = '0;
    endcase
  end

  assign read_data = rd_en ? reg_v : '0;

  // Fold active lines onto the seven request outputs
  always_comb begin
    irq_lines = '0;
    for (int l = 0; l < MAX_LINES; l++) begin
      irq_lines[line_irq_bit(l)] = irq_lines[line_irq_bit(l)] | active_v[l];
    end
  end

endmodule

### hw/rtl/external_interrupt_line_controller.sv
// A result is held in the output register, or in the skid entry while stalled.
// Throughput: one item per cycle while s_tready is high, all lines in parallel.
// A two-entry output buffer (output register plus skid) keeps s_tready high
// while one result waits; s_tready drops only when both entries are full.
// Reset (rst, synchronous, active high) clears all line state and the buffer.
`timescale 1ns / 1ps

module external_interrupt_line_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // reg_addr[2:0], write_data[18:3], sample_port[22:19], pin_levels[38:23], zero
  input  logic [eintc_pkg::IN_TDATA_W-1:0]  s_tdata,
  // req_type[1:0]
  input  logic [eintc_pkg::REQ_W-1:0]       s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // read_data[15:0], irq_lines[22:16], zero
  output logic [eintc_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import eintc_pkg::*;

  logic [ADDR_W-1:0] reg_addr;
  logic [DATA_W-1:0] write_data;
  logic [PORT_W-1:0] sample_port;
  logic [DATA_W-1:0] pin_levels;
  logic              accept;
  logic              is_read, is_write;
  lane_ctl_t         ctl;
  logic [LINE_COUNT-1:0] sel_we;
  lane_stat_t [LINE_COUNT-1:0] stat;
  logic [DATA_W-1:0] read_data;
  logic [IRQ_W-1:0]  irq_lines;
  logic [OUT_TDATA_W-1:0] result;

  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;
  logic                   skid_valid;
  logic [OUT_TDATA_W-1:0] skid_data;

  assign reg_addr    = s_tdata[2:0];
  assign write_data  = s_tdata[18:3];
  assign sample_port = s_tdata[22:19];
  assign pin_levels  = s_tdata[38:23];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign is_read  = accept && (s_tuser == REQ_READ);
  assign is_write = accept && (s_tuser == REQ_WRITE);

  // Write decode into lane controls
  always_comb begin
    ctl.mask_we = 1'b0;
    ctl.rise_we = 1'b0;
    ctl.fall_we = 1'b0;
    ctl.pend_we = 1'b0;
    ctl.sample  = accept && (s_tuser == REQ_SAMPLE);
    ctl.port    = sample_port;
    if (is_write) begin
      unique case (reg_addr) inside
        ADDR_MASK:    ctl.mask_we = 1'b1;
        ADDR_RISING:  ctl.rise_we = 1'b1;
        ADDR_FALLING: ctl.fall_we = 1'b1;
        ADDR_PENDING: ctl.pend_we = 1'b1;
        ADDR_SEL0, ADDR_SEL1, ADDR_SEL2, ADDR_SEL3: ;
        default: ;
      endcase
    end
  end

  // One lane per line
  for (genvar l = 0; l < LINE_COUNT; l++) begin : g_lane
    assign sel_we[l] = is_write && reg_addr[2] && (reg_addr[1:0] == 2'(l / 4));

    eintc_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .sel_we   (sel_we[l]),
      .data_bit (write_data[l]),
      .sel_data (write_data[(l % 4)*SEL_W +: SEL_W]),
      .level    (pin_levels[l]),
      .stat     (stat[l])
    );
  end

  eintc_merge u_merge (
    .stat      (stat),
    .rd_en     (is_read),
    .reg_addr  (reg_addr),
    .read_data (read_data),
    .irq_lines (irq_lines)
  );

  assign result = {1'b0, irq_lines, read_data};

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

### hw/rtl/eintc_checker.sv
`timescale 1ns / 1ps

module eintc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [eintc_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // Input backpressure only when a result is waiting
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // An item into an empty output shows up next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
    else $error("result missing one cycle after item");

  // Nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output not cleared by reset");

endmodule

bind external_interrupt_line_controller eintc_checker u_eintc_checker (.*);
